[hdl/teq_pkg.sv]
// Package: shared constants, types and result kinds for the timed event queue.
package teq_pkg;
  localparam int DefDepth     = 16;
  localparam int DefCondBits  = 4;
  localparam int DefCodeBits  = 8;
  localparam int TimeBits     = 32;
  localparam int ArgBits      = 32;
  localparam int KindBits     = 3;
  localparam int OutCodeBits  = 8;
  localparam int ClearBits    = 8;

  typedef enum logic [KindBits-1:0] {
    KIND_INSERTED = 3'd0,
    KIND_DROPPED  = 3'd1,
    KIND_FIRED    = 3'd2,
    KIND_CLEARED  = 3'd3,
    KIND_ENDED    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_CLOSE
  } state_t;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_PROCESS = 1'b1;
endpackage

[hdl/teq_in_if.sv]
// Interface: input channel of the timed event queue.
interface teq_in_if #(
  parameter int CondBits = teq_pkg::DefCondBits,
  parameter int CodeBits = teq_pkg::DefCodeBits
);
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [teq_pkg::TimeBits-1:0]      now_ms;
  logic [teq_pkg::TimeBits-1:0]      delay_ms;
  logic [CondBits-1:0]               condition;
  logic [CodeBits-1:0]               event_code;
  logic signed [teq_pkg::ArgBits-1:0] arg_first;
  logic signed [teq_pkg::ArgBits-1:0] arg_second;
  modport source (output valid, opcode, now_ms, delay_ms, condition, event_code,
                  arg_first, arg_second, input ready);
  modport sink (input valid, opcode, now_ms, delay_ms, condition, event_code,
                arg_first, arg_second, output ready);
endinterface

[hdl/teq_out_if.sv]
// Interface: result channel of the timed event queue.
interface teq_out_if #(
  parameter int CodeBits = teq_pkg::DefCodeBits
);
  logic                               valid;
  logic                               ready;
  logic [teq_pkg::KindBits-1:0]       kind;
  logic [CodeBits-1:0]                fired_code;
  logic signed [teq_pkg::ArgBits-1:0] fired_first;
  logic signed [teq_pkg::ArgBits-1:0] fired_second;
  logic                               last;
  modport source (output valid, kind, fired_code, fired_first, fired_second, last,
                  input ready);
  modport sink (input valid, kind, fired_code, fired_first, fired_second, last,
                output ready);
endinterface

[hdl/timed_event_queue_core.sv]
// Top level: sorted timed event queue built as a shifting row of slot cells.
//
// The queue holds up to DEPTH events in a row of slot cells, sorted by
// activation time (now_ms + delay_ms, modulo 2^32, unsigned compare). The head
// slot sits at index 0. An insert runs one step per slot: a ripple pass walks
// a cursor that compares the new activation time against each slot; once a
// later time or the end of the queue is met, that slot and all after it shift
// one place toward the tail at once and the new event lands at the cursor,
// then one transfer reports inserted or dropped. A process item examines the
// head side one slot per cycle unless it waits on the result channel: a due
// entry with matching condition is sent out as a fired result and the slots
// behind it shift forward, a mismatch advances the cursor, an entry with the
// clear code empties the queue, and an entry not yet due or the end of the
// queue ends the process. One item is in work at a time; input ready is high
// only in idle. Slots beyond the fill count hold stale data and are never
// examined. clear_code resets to 255.
module timed_event_queue_core #(
  parameter int DEPTH          = teq_pkg::DefDepth,
  parameter int CONDITION_BITS = teq_pkg::DefCondBits,
  parameter int CODE_BITS      = teq_pkg::DefCodeBits
) (
  input  logic                          clk,
  input  logic                          rst,
  teq_in_if.sink                        in_ch,
  teq_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [teq_pkg::ClearBits-1:0] cfg_wdata
);
  localparam int TB = teq_pkg::TimeBits;
  localparam int AB = teq_pkg::ArgBits;
  localparam int W  = TB + CONDITION_BITS + CODE_BITS + 2 * AB;
  localparam int IB = $clog2(DEPTH);
  localparam int CB = $clog2(DEPTH + 1);

  teq_pkg::state_t state, state_next;

  logic [teq_pkg::ClearBits-1:0] clear_code;
  logic [CB-1:0]                 count;
  logic [CB-1:0]                 cursor;   // slot under examination
  logic                          op_process;
  logic [TB-1:0]                 act;      // insert: activation, process: now
  logic [CONDITION_BITS-1:0]     cond;
  logic [W-1:0]                  new_entry;
  logic                          ins_done; // insert placed its entry

  logic [W-1:0] slots [DEPTH];
  logic [DEPTH-1:0] ld_prev, ld_next;

  // result register
  logic                      ovalid;
  logic [teq_pkg::KindBits-1:0] okind;
  logic [CODE_BITS-1:0]      ocode;
  logic [AB-1:0]             ofirst, osecond;
  logic                      olast;

  // fields of the slot under the cursor
  logic [W-1:0]              cur;
  logic [TB-1:0]             cur_time;
  logic [CONDITION_BITS-1:0] cur_cond;
  logic [CODE_BITS-1:0]      cur_code;
  logic [AB-1:0]             cur_first, cur_second;
  logic                      at_end;

  assign cur = slots[cursor[IB-1:0]];
  assign {cur_time, cur_cond, cur_code, cur_first, cur_second} = cur;
  assign at_end = (cursor >= count);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_slot
      logic [W-1:0] prev_e, next_e;
      if (g == 0) begin : g_head
        assign prev_e = new_entry;
      end else begin : g_mid
        assign prev_e = (cursor == CB'(g)) ? new_entry : slots[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign next_e = slots[g];
      end else begin : g_body
        assign next_e = slots[g+1];
      end
      teq_cell #(.CondBits(CONDITION_BITS), .CodeBits(CODE_BITS), .W(W)) u_cell (
        .clk        (clk),
        .load_prev  (ld_prev[g]),
        .load_next  (ld_next[g]),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .entry      (slots[g])
      );
    end
  endgenerate

  logic out_free;
  assign out_free = !ovalid || out_ch.ready;
  assign in_ch.ready = (state == teq_pkg::ST_IDLE);

  // control decisions of one step
  logic do_insert_place, do_fire, do_clear, do_end, do_skip;

  always_comb begin
    state_next      = state;
    ld_prev         = '0;
    ld_next         = '0;
    do_insert_place = 1'b0;
    do_fire         = 1'b0;
    do_clear        = 1'b0;
    do_end          = 1'b0;
    do_skip         = 1'b0;
    case (state)
      teq_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_next = teq_pkg::ST_SCAN;
        end
      end
      teq_pkg::ST_SCAN: begin
        if (!op_process) begin
          // insert: advance the cursor past equal or earlier entries
          if (count >= CB'(DEPTH)) begin
            state_next = teq_pkg::ST_CLOSE;
          end else if (at_end || cur_time > act) begin
            do_insert_place = 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              ld_prev[i] = (CB'(i) >= cursor) && (CB'(i) <= count);
            end
            state_next = teq_pkg::ST_CLOSE;
          end else begin
            do_skip = 1'b1;
          end
        end else if (at_end) begin
          do_end = 1'b1;
        end else if (cur_code == CODE_BITS'(clear_code)
                     && (CODE_BITS >= teq_pkg::ClearBits
                         || (clear_code >> CODE_BITS) == '0)) begin
          do_clear = 1'b1;
        end else if (cur_time > act) begin
          do_end = 1'b1;
        end else if (cur_cond == cond) begin
          if (out_free) begin
            do_fire = 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              ld_next[i] = (CB'(i) >= cursor);
            end
          end
        end else begin
          do_skip = 1'b1;
        end
        if ((do_end || do_clear) && out_free) begin
          state_next = teq_pkg::ST_IDLE;
        end
        if ((do_end || do_clear) && !out_free) begin
          do_end   = 1'b0;
          do_clear = 1'b0;
        end
      end
      teq_pkg::ST_CLOSE: begin
        if (out_free) begin
          state_next = teq_pkg::ST_IDLE;
        end
      end
      default: state_next = teq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= teq_pkg::ST_IDLE;
      count      <= '0;
      clear_code <= '1;
      ovalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        clear_code <= cfg_wdata;
      end
      if (ovalid && out_ch.ready) begin
        ovalid <= 1'b0;
      end
      if (do_insert_place) begin
        count <= count + 1'b1;
      end
      if (do_clear) begin
        count <= '0;
      end
      if (do_fire) begin
        count  <= count - 1'b1;
        ovalid <= 1'b1;
      end
      if (do_end || do_clear) begin
        ovalid <= 1'b1;
      end
      if (state == teq_pkg::ST_CLOSE && out_free) begin
        ovalid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == teq_pkg::ST_IDLE && in_ch.valid) begin
      op_process <= (in_ch.opcode == teq_pkg::OP_PROCESS);
      act        <= (in_ch.opcode == teq_pkg::OP_PROCESS) ? in_ch.now_ms
                                                          : in_ch.now_ms + in_ch.delay_ms;
      cond       <= in_ch.condition;
      new_entry  <= {in_ch.now_ms + in_ch.delay_ms, in_ch.condition, in_ch.event_code,
                     in_ch.arg_first, in_ch.arg_second};
      cursor     <= '0;
    end else if (do_skip) begin
      cursor <= cursor + 1'b1;
    end
    if (do_fire) begin
      okind   <= teq_pkg::KIND_FIRED;
      ocode   <= cur_code;
      ofirst  <= cur_first;
      osecond <= cur_second;
      olast   <= 1'b0;
    end else if (do_end || do_clear) begin
      okind   <= do_clear ? teq_pkg::KIND_CLEARED : teq_pkg::KIND_ENDED;
      ocode   <= '0;
      ofirst  <= '0;
      osecond <= '0;
      olast   <= 1'b1;
    end else if (state == teq_pkg::ST_CLOSE && out_free) begin
      okind   <= (count >= CB'(DEPTH) && !do_insert_place && cursor == '0
                  && op_process == 1'b0 && !ins_done) ? teq_pkg::KIND_DROPPED
                                                       : teq_pkg::KIND_INSERTED;
      ocode   <= '0;
      ofirst  <= '0;
      osecond <= '0;
      olast   <= 1'b1;
    end
  end

  // mark whether the insert placed its entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ins_done <= 1'b0;
    end else if (do_insert_place) begin
      ins_done <= 1'b1;
    end else if (state == teq_pkg::ST_IDLE) begin
      ins_done <= 1'b0;
    end
  end

  assign out_ch.valid        = ovalid;
  assign out_ch.kind         = okind;
  assign out_ch.fired_code   = ocode;
  assign out_ch.fired_first  = ofirst;
  assign out_ch.fired_second = osecond;
  assign out_ch.last         = olast;
endmodule

[hdl/teq_cell.sv]
// Module: one queue slot; holds an entry and shifts with its neighbors.
module teq_cell #(
  parameter int CondBits = teq_pkg::DefCondBits,
  parameter int CodeBits = teq_pkg::DefCodeBits,
  parameter int W = teq_pkg::TimeBits + CondBits + CodeBits + 2 * teq_pkg::ArgBits
) (
  input  logic         clk,
  input  logic         load_prev,  // take the entry of the slot before
  input  logic         load_next,  // take the entry of the slot after
  input  logic [W-1:0] prev_entry,
  input  logic [W-1:0] next_entry,
  output logic [W-1:0] entry
);
  always_ff @(posedge clk) begin
    if (load_prev) begin
      entry <= prev_entry;
    end else if (load_next) begin
      entry <= next_entry;
    end
  end
endmodule
